[rtl/radial_alpha_mask_defines.svh]
// Assertion macros shared by the checker.
`ifndef RADIAL_ALPHA_MASK_DEFINES_SVH
`define RADIAL_ALPHA_MASK_DEFINES_SVH

// Implication on the same edge, masked while reset is low.
`define RMASK_AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmask check failed: ante -> cons");

// Implication on the next edge, checked through reset as well.
`define RMASK_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rmask check failed: ante => cons");

`endif

[rtl/rmask_pkg.sv]
package rmask_pkg;

  localparam int unsigned FRAC_BITS   = 4;
  localparam int unsigned CX_W        = 9;
  localparam int unsigned CY_W        = 8;
  localparam int unsigned DXY_W       = 10;
  localparam int unsigned SQ_W        = 19;
  localparam int unsigned RAD_W       = 15;
  localparam int unsigned ALPHA_W     = 8;
  localparam int unsigned N_W         = SQ_W + 2 * FRAC_BITS;
  localparam int unsigned SQRT_ITERS  = (N_W + 1) / 2;
  localparam int unsigned ROOT_W      = SQRT_ITERS;
  localparam int unsigned REM_W       = N_W + 1;
  localparam int unsigned SQRT_PER    = 2;
  localparam int unsigned SQRT_STGS   = (SQRT_ITERS + SQRT_PER - 1) / SQRT_PER;
  localparam int unsigned DS_W        = RAD_W + 2;
  localparam int unsigned DEN_W       = RAD_W + 1;
  localparam int unsigned NUM_W       = DEN_W + ALPHA_W;
  localparam int unsigned DIV_PER     = 2;
  localparam int unsigned DIV_STGS    = ALPHA_W / DIV_PER;
  localparam int unsigned LATENCY     = 2 + SQRT_STGS + 2 + DIV_STGS + 1;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = RAD_W;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;
  localparam logic signed [DS_W-1:0] IRIS_MIN = DS_W'(20 << FRAC_BITS);
  localparam logic signed [DS_W-1:0] IRIS_FEATHER = DS_W'(25 << FRAC_BITS);

  localparam logic MODE_RAMP = 1'b0;
  localparam logic MODE_IRIS = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    REG_MODE  = 3'd0,
    REG_CX    = 3'd1,
    REG_CY    = 3'd2,
    REG_INNER = 3'd3,
    REG_OUTER = 3'd4,
    REG_IRIS  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0]   rem;
    logic [ALPHA_W-1:0] nlow;
    logic [ALPHA_W-1:0] quo;
    logic [DEN_W-1:0]   den;
    logic               forced;
    logic [ALPHA_W-1:0] fval;
  } div_t;

  // One digit-pair step of the bitwise square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s, input int unsigned k);
    logic [REM_W-1:0] bitv;
    logic [REM_W-1:0] trial;
    sqrt_t            r;
    bitv  = REM_W'(1) << (2 * (SQRT_ITERS - 1 - k));
    trial = s.root + bitv;
    r     = s;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // One quotient bit of restoring division.
  function automatic div_t div_step(input div_t s);
    logic [DEN_W:0] t;
    div_t           r;
    t      = {s.rem, s.nlow[ALPHA_W-1]};
    r      = s;
    r.nlow = s.nlow << 1;
    if (t >= {1'b0, s.den}) begin
      t     = t - {1'b0, s.den};
      r.quo = {s.quo[ALPHA_W-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[ALPHA_W-2:0], 1'b0};
    end
    r.rem = t[DEN_W-1:0];
    return r;
  endfunction

endpackage

[rtl/rmask_sqrt_stg.sv]
module rmask_sqrt_stg
  import rmask_pkg::*;
#(
  parameter int unsigned STG = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  sqrt_t s_i,
  output logic  vld_o,
  output sqrt_t s_o
);

  logic  vld_r;
  sqrt_t s_r;
  sqrt_t s_nxt;

  // Run this stage's share of root iterations
  always_comb begin
    s_nxt = s_i;
    for (int unsigned j = 0; j < SQRT_PER; j++) begin
      if (STG * SQRT_PER + j < SQRT_ITERS) begin
        s_nxt = sqrt_step(s_nxt, STG * SQRT_PER + j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign vld_o = vld_r;
  assign s_o   = s_r;

endmodule

[rtl/rmask_div_stg.sv]
module rmask_div_stg
  import rmask_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  div_t s_i,
  output logic vld_o,
  output div_t s_o
);

  logic vld_r;
  div_t s_r;
  div_t s_nxt;

  // Produce this stage's quotient bits
  always_comb begin
    s_nxt = s_i;
    for (int unsigned j = 0; j < DIV_PER; j++) begin
      s_nxt = div_step(s_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign vld_o = vld_r;
  assign s_o   = s_r;

endmodule

[rtl/radial_alpha_mask.sv]
// Throughput: one pixel per clock; busy is low whenever out of reset.
// Stages: offsets, squares, 7 root stages (2 bits each), compare, scale,
// 4 divider stages (2 quotient bits each), output register.
// Synchronous reset clears the pipeline and loads the register defaults.
// Results cannot be stalled by the receiver.
module radial_alpha_mask
  import rmask_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CX_W-1:0]     in_pix_x,
  input  logic [CY_W-1:0]     in_pix_y,
  output logic                out_valid,
  output logic [ALPHA_W-1:0]  out_alpha,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_data
);

  logic                     busy_r;
  logic                     mode_r;
  logic [CX_W-1:0]          cx_r;
  logic [CY_W-1:0]          cy_r;
  logic signed [RAD_W-1:0]  inner_r;
  logic signed [RAD_W-1:0]  outer_r;
  logic signed [RAD_W-1:0]  iris_r;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      mode_r  <= MODE_RAMP;
      cx_r    <= CX_W'(160);
      cy_r    <= CY_W'(120);
      inner_r <= -RAD_W'(80);
      outer_r <= RAD_W'(560);
      iris_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_addr)
          REG_MODE:  mode_r  <= cfg_data[0];
          REG_CX:    cx_r    <= cfg_data[CX_W-1:0];
          REG_CY:    cy_r    <= cfg_data[CY_W-1:0];
          REG_INNER: inner_r <= cfg_data;
          REG_OUTER: outer_r <= cfg_data;
          REG_IRIS:  iris_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Stage 1: offsets from the centre
  logic                     v1_r;
  logic signed [DXY_W-1:0]  dx_r;
  logic signed [DXY_W-1:0]  dy_r;

  // Stage 2: squared distance
  logic                     v2_r;
  logic [SQ_W-1:0]          sq_r;
  logic signed [2*DXY_W-1:0] dxsq;
  logic signed [2*DXY_W-1:0] dysq;

  assign dxsq = dx_r * dx_r;
  assign dysq = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= signed'({{(DXY_W-CX_W){1'b0}}, in_pix_x})
          - signed'({{(DXY_W-CX_W){1'b0}}, cx_r});
    dy_r <= signed'({{(DXY_W-CY_W){1'b0}}, in_pix_y})
          - signed'({{(DXY_W-CY_W){1'b0}}, cy_r});
    sq_r <= dxsq[SQ_W-1:0] + dysq[SQ_W-1:0];
  end

  // Root pipeline
  logic  sv [SQRT_STGS+1];
  sqrt_t ss [SQRT_STGS+1];

  assign sv[0]      = v2_r;
  assign ss[0].rem  = REM_W'(sq_r) << (2 * FRAC_BITS);
  assign ss[0].root = '0;

  for (genvar g = 0; g < SQRT_STGS; g++) begin : g_sqrt
    rmask_sqrt_stg #(.STG(g)) u_stg (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (sv[g]),
      .s_i   (ss[g]),
      .vld_o (sv[g+1]),
      .s_o   (ss[g+1])
    );
  end

  // Compare stage: pick forced result or divider operands
  logic                     vc_r;
  logic [DEN_W-1:0]         diff_r;
  logic [DEN_W-1:0]         den_r;
  logic                     forced_r;
  logic [ALPHA_W-1:0]       fval_r;
  logic signed [DS_W-1:0]   ds;
  logic signed [DS_W-1:0]   ri;
  logic signed [DS_W-1:0]   ro;
  logic signed [DS_W-1:0]   rr;
  logic signed [DS_W-1:0]   dr;
  logic [DEN_W-1:0]         diff_nxt;
  logic [DEN_W-1:0]         den_nxt;
  logic                     forced_nxt;
  logic [ALPHA_W-1:0]       fval_nxt;

  always_comb begin
    ds         = signed'({{(DS_W-ROOT_W){1'b0}}, ss[SQRT_STGS].root[ROOT_W-1:0]});
    ri         = DS_W'(inner_r);
    ro         = DS_W'(outer_r);
    rr         = DS_W'(iris_r);
    dr         = ds - rr;
    diff_nxt   = '0;
    den_nxt    = DEN_W'(1);
    forced_nxt = 1'b1;
    fval_nxt   = '0;
    if (mode_r == MODE_RAMP) begin
      if (ds < ri) begin
        fval_nxt = '0;
      end else if (ro < ds) begin
        fval_nxt = ALPHA_MAX;
      end else if (ro == ri) begin
        fval_nxt = '0;
      end else begin
        forced_nxt = 1'b0;
        diff_nxt   = DEN_W'(ds - ri);
        den_nxt    = DEN_W'(ro - ri);
      end
    end else begin
      if (rr < IRIS_MIN) begin
        fval_nxt = ALPHA_MAX;
      end else if (ds <= rr) begin
        fval_nxt = '0;
      end else if (dr >= IRIS_FEATHER) begin
        fval_nxt = ALPHA_MAX;
      end else begin
        forced_nxt = 1'b0;
        diff_nxt   = DEN_W'(dr);
        den_nxt    = DEN_W'(IRIS_FEATHER);
      end
    end
  end

  // Scale stage: numerator is diff * 255
  logic               vm_r;
  div_t               dm_r;
  logic [NUM_W-1:0]   num;

  assign num = (NUM_W'(diff_r) << ALPHA_W) - NUM_W'(diff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vm_r <= 1'b0;
    end else begin
      vc_r <= sv[SQRT_STGS];
      vm_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r      <= diff_nxt;
    den_r       <= den_nxt;
    forced_r    <= forced_nxt;
    fval_r      <= fval_nxt;
    dm_r.rem    <= num[NUM_W-1:ALPHA_W];
    dm_r.nlow   <= num[ALPHA_W-1:0];
    dm_r.quo    <= '0;
    dm_r.den    <= den_r;
    dm_r.forced <= forced_r;
    dm_r.fval   <= fval_r;
  end

  // Divider pipeline
  logic dv [DIV_STGS+1];
  div_t dd [DIV_STGS+1];

  assign dv[0] = vm_r;
  assign dd[0] = dm_r;

  for (genvar g = 0; g < DIV_STGS; g++) begin : g_div
    rmask_div_stg u_stg (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (dv[g]),
      .s_i   (dd[g]),
      .vld_o (dv[g+1]),
      .s_o   (dd[g+1])
    );
  end

  // Output register
  logic               out_valid_r;
  logic [ALPHA_W-1:0] out_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv[DIV_STGS];
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r <= dd[DIV_STGS].forced ? dd[DIV_STGS].fval : dd[DIV_STGS].quo;
  end

  assign out_valid = out_valid_r;
  assign out_alpha = out_alpha_r;

endmodule

[rtl/rmask_chk.sv]
`include "radial_alpha_mask_defines.svh"

module rmask_chk
  import rmask_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  // Every result beat traces back to one earlier accepted start beat
  `RMASK_AST_IMP(a_out_from_start, out_valid, $past(start && !busy, LATENCY))
  // Reset empties the pipeline and holds off new beats
  `RMASK_AST_NXT(a_reset_clears, !rst_n, !out_valid && busy)
  // Out of reset the block always takes pixels and register writes
  `RMASK_AST_NXT(a_always_ready, rst_n, !busy && cfg_ready)

endmodule

bind radial_alpha_mask rmask_chk u_rmask_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);

[dv/tb_radial_alpha_mask.sv]
`timescale 1ns / 100ps

module tb_radial_alpha_mask;
  import rmask_pkg::*;

  // Mask configuration as the block holds it
  typedef struct {
    logic                   mode;
    logic [CX_W-1:0]        cx;
    logic [CY_W-1:0]        cy;
    logic signed [RAD_W-1:0] inner;
    logic signed [RAD_W-1:0] outer;
    logic signed [RAD_W-1:0] iris;
  } mask_cfg_t;

  // Register index past the end of the list; the block ignores it
  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(3'd6);

  int unsigned n_mismatch = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  // Pending alpha values, one per accepted pixel
  class alpha_scoreboard;
    logic [ALPHA_W-1:0] alpha_q[$];
    mask_cfg_t          cfg;
    int unsigned        n_checked = 0;

    // Floor of the square root, one bit of the root per pass
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function automatic logic [ALPHA_W-1:0] mask_alpha(input logic [CX_W-1:0] px,
                                                      input logic [CY_W-1:0] py);
      longint dx, dy, d, lo, hi, r, a;
      dx = longint'(px) - longint'(cfg.cx);
      dy = longint'(py) - longint'(cfg.cy);
      d  = longint'(floor_sqrt(longint'(dx * dx + dy * dy) << (2 * FRAC_BITS)));
      if (cfg.mode == MODE_RAMP) begin
        lo = cfg.inner;
        hi = cfg.outer;
        if (d < lo) a = 0;
        else if (hi < d) a = 255;
        else if (hi == lo) a = 0;
        else a = ((d - lo) * 255) / (hi - lo);
      end else begin
        r = cfg.iris;
        if (r < (20 << FRAC_BITS)) a = 255;
        else if (d <= r) a = 0;
        else begin
          a = ((d - r) * 255) / (25 << FRAC_BITS);
          if (a > 255) a = 255;
        end
      end
      return ALPHA_W'(a);
    endfunction

    function void note_pixel(input logic [CX_W-1:0] px, input logic [CY_W-1:0] py);
      alpha_q.push_back(mask_alpha(px, py));
    endfunction

    task check_alpha(input logic [ALPHA_W-1:0] got);
      logic [ALPHA_W-1:0] want;
      if (alpha_q.size() == 0) begin
        report_mismatch($sformatf("unexpected alpha %0d", got));
        return;
      end
      want = alpha_q.pop_front();
      n_checked++;
      if (got !== want)
        report_mismatch($sformatf("alpha got %0d want %0d", got, want));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CX_W-1:0]     in_pix_x;
  logic [CY_W-1:0]     in_pix_y;
  logic                out_valid;
  logic [ALPHA_W-1:0]  out_alpha;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_data;

  alpha_scoreboard sb;
  int unsigned     n_cfg = 0;

  radial_alpha_mask dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result beat at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_alpha(out_alpha);
  end

  // Short idle, occasionally a long one
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  // Write one register and mirror it in the scoreboard
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:  sb.cfg.mode  = val[0];
      REG_CX:    sb.cfg.cx    = val[CX_W-1:0];
      REG_CY:    sb.cfg.cy    = val[CY_W-1:0];
      REG_INNER: sb.cfg.inner = val;
      REG_OUTER: sb.cfg.outer = val;
      REG_IRIS:  sb.cfg.iris  = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drive one pixel beat, holding start until accepted
  task automatic send_pixel(input logic [CX_W-1:0] px, input logic [CY_W-1:0] py);
    start    <= 1'b1;
    in_pix_x <= px;
    in_pix_y <= py;
    do @(posedge clk); while (busy);
    sb.note_pixel(px, py);
    @(negedge clk);
  endtask

  task automatic drop_start();
    start <= 1'b0;
  endtask

  // Drain all pending results, then let the pipeline settle
  task automatic drain();
    drop_start();
    while (sb.alpha_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic random_pixels(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_pixel($urandom, $urandom);
      else send_pixel($urandom_range(0, 319), $urandom_range(0, 239));
      if ($urandom_range(0, 2) == 0) begin
        drop_start();
        @(negedge clk);
        idle_gap();
      end
    end
  endtask

  task automatic set_all(input logic m, input logic [CX_W-1:0] cx, input logic [CY_W-1:0] cy,
                         input logic [RAD_W-1:0] ri, input logic [RAD_W-1:0] ro,
                         input logic [RAD_W-1:0] rr);
    write_reg(REG_MODE, CFG_DW'(m));
    write_reg(REG_CX, CFG_DW'(cx));
    write_reg(REG_CY, CFG_DW'(cy));
    write_reg(REG_INNER, ri);
    write_reg(REG_OUTER, ro);
    write_reg(REG_IRIS, rr);
  endtask

  initial begin
    sb = new();
    sb.cfg = '{mode: MODE_RAMP, cx: 9'd160, cy: 8'd120, inner: -15'sd80,
               outer: 15'sd560, iris: 15'sd0};
    rst_n = 1'b0; start = 1'b0; in_pix_x = '0; in_pix_y = '0;
    cfg_valid = 1'b0; cfg_addr = '0; cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset settings, coordinate extremes
    send_pixel(9'd160, 8'd120);
    send_pixel(9'd0, 8'd0);
    send_pixel(9'd511, 8'd255);
    send_pixel(9'd319, 8'd239);
    send_pixel(9'd0, 8'd255);
    send_pixel(9'd511, 8'd0);
    send_pixel(9'd170, 8'd140);
    drain();

    // Equal ramp radii: the distance equal to both gives zero
    set_all(MODE_RAMP, 9'd100, 8'd100, 15'sd160, 15'sd160, 15'sd0);
    send_pixel(9'd110, 8'd100);
    send_pixel(9'd111, 8'd100);
    send_pixel(9'd100, 8'd100);
    drain();
    // Outer below inner
    set_all(MODE_RAMP, 9'd0, 8'd0, 15'sd800, 15'sd100, 15'sd0);
    send_pixel(9'd10, 8'd0);
    send_pixel(9'd60, 8'd0);
    send_pixel(9'd3, 8'd4);
    drain();
    // Iris below minimum, at minimum, and extremes
    set_all(MODE_IRIS, 9'd319, 8'd239, 15'sd0, 15'sd0, 15'sd319);
    send_pixel(9'd319, 8'd239);
    drain();
    write_reg(REG_IRIS, 15'sd320);
    send_pixel(9'd319, 8'd239);
    send_pixel(9'd299, 8'd239);
    send_pixel(9'd340, 8'd239);
    send_pixel(9'd0, 8'd0);
    drain();
    write_reg(REG_IRIS, 15'h3FFF);
    send_pixel(9'd0, 8'd0);
    drain();
    write_reg(REG_IRIS, 15'h4000);
    send_pixel(9'd0, 8'd0);
    drain();
    write_reg(REG_UNUSED, '0);
    drain();

    // Random phases with varied settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_all(MODE_RAMP, 9'd0, 8'd0, 15'h4000, 15'h3FFF, 15'h4000);
        1: set_all(MODE_IRIS, 9'd511, 8'd255, 15'h3FFF, 15'h4000, 15'sd400);
        2: set_all(MODE_RAMP, 9'd160, 8'd120, 15'sd0, 15'sd1600, 15'sd0);
        default: set_all($urandom, $urandom, $urandom,
                         ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000)),
                         ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 6000)),
                         ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000)));
      endcase
      random_pixels(50);
      drain();
    end

    $display("Covered %0d pixels and %0d register writes in ramp and iris modes.",
             sb.n_checked, n_cfg);
    if (n_mismatch == 0 && sb.alpha_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
